// ===== rtl/pcxrd_pkg.sv =====
// Shared types and constants for the PCX run-length row decoder.
// No dependencies; every other file refers to this package by scoped names.
package pcxrd_pkg;

  // Field and state widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned REG_W   = 13;
  localparam int unsigned COL_W   = 13;
  localparam int unsigned ROW_W   = 12;

  // A byte at or above this mark is a count byte
  localparam logic [BYTE_W-1:0] COUNT_MARK = 8'd192;

  // Saturation limits for the encoded line length and the row count
  localparam logic [REG_W-1:0] MAX_LINE_BYTES = 13'd4096;
  localparam logic [REG_W-1:0] MAX_ROWS       = 13'd4096;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LINE_BYTES   = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_ROW_STRIDE   = 2'd3
  } reg_index_t;

  // Configuration registers as seen by the back end
  typedef struct packed {
    logic [REG_W-1:0] line_bytes;
    logic [REG_W-1:0] image_width;
    logic [REG_W-1:0] image_height;
    logic [REG_W-1:0] row_stride;
  } cfg_regs_t;

  // One run to carry out: a value and how often it repeats
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_value;
    logic [REG_W-1:0]  repeat_res;
    logic              row_end;
    logic              image_end;
    logic              last;
  } result_t;

endpackage

// ===== rtl/pcxrd_front.sv =====
// Front end of the PCX row decoder: accepts compressed bytes and folds
// count bytes into run commands. Depends on pcxrd_pkg.
module pcxrd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  logic [pcxrd_pkg::BYTE_W-1:0]  byte_data,
  output logic                          cmd_push,
  output pcxrd_pkg::cmd_t               cmd_data,
  input  logic                          cmd_full
);

  logic                         await_r, await_nxt;
  logic [pcxrd_pkg::CNT_W-1:0]  pend_r, pend_nxt;
  logic                         take;

  assign byte_ready = !cmd_full;
  assign take       = byte_valid && byte_ready;

  // Classify the accepted byte: count, run value or literal
  always_comb begin
    await_nxt      = await_r;
    pend_nxt       = pend_r;
    cmd_push       = 1'b0;
    cmd_data.value = byte_data;
    cmd_data.count = pcxrd_pkg::CNT_W'(1);
    if (take) begin
      if (await_r) begin
        cmd_push       = 1'b1;
        cmd_data.count = pend_r;
        await_nxt      = 1'b0;
        pend_nxt       = '0;
      end else if (byte_data >= pcxrd_pkg::COUNT_MARK) begin
        await_nxt = 1'b1;
        pend_nxt  = byte_data[pcxrd_pkg::CNT_W-1:0];
      end else begin
        cmd_push = 1'b1;
      end
    end
  end

  // Hold the pending count between a count byte and its value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b0;
      pend_r  <= '0;
    end else begin
      await_r <= await_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ===== rtl/pcxrd_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on pcxrd_pkg for the command type and depth.
module pcxrd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pcxrd_pkg::cmd_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output pcxrd_pkg::cmd_t  pop_data
);

  localparam int unsigned CW = pcxrd_pkg::QUEUE_AW + 1;

  pcxrd_pkg::cmd_t                  mem_r [pcxrd_pkg::QUEUE_DEPTH];
  logic [pcxrd_pkg::QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]                    fill_r;
  logic                             do_push, do_pop;

  assign full     = (fill_r == CW'(pcxrd_pkg::QUEUE_DEPTH));
  assign avail    = (fill_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pcxrd_back.sv =====
// Back end of the PCX row decoder: tracks column and row, clips runs,
// emits padding at row end. Depends on pcxrd_pkg.
module pcxrd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcxrd_pkg::cfg_regs_t  cfg,
  input  logic                  cmd_avail,
  input  pcxrd_pkg::cmd_t       cmd_data,
  output logic                  cmd_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pcxrd_pkg::result_t    res_data
);

  localparam int unsigned CW = pcxrd_pkg::COL_W;
  localparam int unsigned RW = pcxrd_pkg::ROW_W;
  localparam int unsigned GW = pcxrd_pkg::REG_W;

  logic [CW-1:0]       column_r, column_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  pcxrd_pkg::result_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  pcxrd_pkg::result_t  pend_r, pend_nxt;
  logic                pend_valid_r, pend_valid_nxt;

  logic [CW-1:0]       end_col;
  logic [GW-1:0]       clip_end;
  logic [GW-1:0]       visible;
  logic                has_run;
  logic [GW-1:0]       limit;
  logic                row_done;
  logic [GW-1:0]       pad;
  logic [GW-1:0]       row_inc;
  logic                img_done;
  logic                out_free;
  logic                take;
  pcxrd_pkg::result_t  run_res, pad_res;

  // Column arithmetic for the command at the head of the queue
  always_comb begin
    end_col  = column_r + CW'(cmd_data.count);
    clip_end = (end_col < cfg.image_width) ? end_col : cfg.image_width;
    visible  = (column_r < cfg.image_width) ? (clip_end - column_r) : '0;
    has_run  = (visible != '0);
    limit    = (cfg.line_bytes < pcxrd_pkg::MAX_LINE_BYTES) ?
               cfg.line_bytes : pcxrd_pkg::MAX_LINE_BYTES;
    row_done = (end_col >= limit);
    pad      = (cfg.row_stride > clip_end) ? (cfg.row_stride - clip_end) : '0;
    row_inc  = {1'b0, row_r} + GW'(1);
    img_done = (row_inc >= cfg.image_height) || (row_inc >= pcxrd_pkg::MAX_ROWS);
  end

  // Build the two possible results
  always_comb begin
    run_res.pixel_value = cmd_data.value;
    run_res.repeat_res  = visible;
    run_res.row_end     = 1'b0;
    run_res.image_end   = 1'b0;
    run_res.last        = !row_done;
    pad_res.pixel_value = '0;
    pad_res.repeat_res  = pad;
    pad_res.row_end     = 1'b1;
    pad_res.image_end   = img_done;
    pad_res.last        = 1'b1;
  end

  assign take      = out_valid_r && res_ready;
  assign out_free  = !out_valid_r || res_ready;
  assign cmd_pop   = cmd_avail && out_free && !pend_valid_r;
  assign res_valid = out_valid_r;
  assign res_data  = out_r;

  // Advance state and the output stage
  always_comb begin
    column_nxt     = column_r;
    row_nxt        = row_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !take;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (pend_valid_r) begin
      if (take) begin
        out_nxt        = pend_r;
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end else if (cmd_pop) begin
      if (row_done) begin
        column_nxt = '0;
        row_nxt    = img_done ? '0 : row_inc[RW-1:0];
      end else begin
        column_nxt = end_col;
      end
      if (has_run) begin
        out_nxt        = run_res;
        out_valid_nxt  = 1'b1;
        pend_nxt       = pad_res;
        pend_valid_nxt = row_done;
      end else if (row_done) begin
        out_nxt       = pad_res;
        out_valid_nxt = 1'b1;
      end
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

`ifndef SYNTH
  // A parked padding result always sits behind a run result
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r && !out_r.last && !out_r.row_end)
    else $error("padding parked without a run result ahead of it");

  // A parked result is always the closing padding of a row
  a_pend_is_pad: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> pend_r.row_end && pend_r.last && (pend_r.pixel_value == '0))
    else $error("parked result is not a row padding");

  // The column never stays at or past the saturated line length
  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    column_r < pcxrd_pkg::MAX_LINE_BYTES)
    else $error("column beyond line length");

  // Only a row end may carry an image end
  a_image_end_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.image_end |-> out_r.row_end)
    else $error("image end without row end");
`endif

endmodule

// ===== rtl/pcx_rle_row_decoder_core.sv =====
// Top level of the PCX run-length row decoder: config registers, front end,
// command queue and back end. Depends on pcxrd_pkg and the pcxrd_* modules.
// A command formed by the front end is stored in the command queue, then popped and its
// result registered in the output stage. The input takes one byte per cycle while the
// queue is not full; a byte that ends a row after a visible run yields a run result and
// a padding result parked behind it, and queue pops stall while the padding is parked.
// Reset (rst_n, synchronous, low) clears column, row, queue and output stage; registers return to 1,1,1,4.
module pcx_rle_row_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] code_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [7:0] pixel_value, [20:8] repeat_res, [23:21] zero
  output logic [1:0]  out_tuser,   // [0] row_end, [1] image_end
  output logic        out_tlast,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  pcxrd_pkg::cfg_regs_t  cfg_r;
  logic                  cmd_push, cmd_full, cmd_pop, cmd_avail;
  pcxrd_pkg::cmd_t       cmd_in, cmd_out;
  pcxrd_pkg::result_t    res;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_bytes   <= 13'd1;
      cfg_r.image_width  <= 13'd1;
      cfg_r.image_height <= 13'd1;
      cfg_r.row_stride   <= 13'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pcxrd_pkg::reg_index_t'(cfg_index))
        pcxrd_pkg::REG_LINE_BYTES:   cfg_r.line_bytes   <= cfg_data;
        pcxrd_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        pcxrd_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data;
        pcxrd_pkg::REG_ROW_STRIDE:   cfg_r.row_stride   <= cfg_data;
        default: ;
      endcase
    end
  end

  pcxrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_ready (in_tready),
    .byte_data  (in_tdata),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_in),
    .cmd_full   (cmd_full)
  );

  pcxrd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .avail     (cmd_avail),
    .pop_data  (cmd_out)
  );

  pcxrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_avail (cmd_avail),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (res)
  );

  // Pack the result transfer
  assign out_tdata = {3'b000, res.repeat_res, res.pixel_value};
  assign out_tuser = {res.image_end, res.row_end};
  assign out_tlast = res.last;

endmodule
